### sv/lru_pkg.sv
// Shared types and constants for the LRU order list unit.
`default_nettype none
package lru_pkg;

   localparam int ENTRIES = 64;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int LINK_W  = $clog2(ENTRIES + 1);

   localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(ENTRIES);

   localparam logic [1:0] OP_TOUCH  = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   typedef struct packed {
      logic [1:0]       operation;
      logic [IDX_W-1:0] entry_index;
   } req_type;

   typedef struct packed {
      logic [LINK_W-1:0] head_entry;
      logic [LINK_W-1:0] tail_entry;
      logic              list_empty;
      logic              op_error;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_UNLINK,
      ST_LINK_A,
      ST_LINK_B,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic check;
      logic unlink;
      logic link_a;
      logic link_b;
   } cmd_type;

   typedef struct packed {
      logic op_error;
      logic is_add;
      logic is_touch;
      logic at_head;
   } sts_type;

endpackage
`default_nettype wire

### sv/lru_ctrl.sv
// Sequencing state machine for the LRU order list unit.
`default_nettype none
module lru_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire lru_pkg::sts_type sts,
   output lru_pkg::cmd_type      cmd,
   output logic                  busy,
   output logic                  rsp_valid
);

   lru_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lru_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lru_pkg::ST_IDLE: begin
            if (start) state_in = lru_pkg::ST_CHECK;
         end
         lru_pkg::ST_CHECK: begin
            priority if (sts.op_error) state_in = lru_pkg::ST_RESP;
            else if (sts.is_add) state_in = lru_pkg::ST_LINK_A;
            else if (sts.is_touch && sts.at_head) state_in = lru_pkg::ST_RESP;
            else state_in = lru_pkg::ST_UNLINK;
         end
         lru_pkg::ST_UNLINK: begin
            state_in = sts.is_touch ? lru_pkg::ST_LINK_A : lru_pkg::ST_RESP;
         end
         lru_pkg::ST_LINK_A: state_in = lru_pkg::ST_LINK_B;
         lru_pkg::ST_LINK_B: state_in = lru_pkg::ST_RESP;
         lru_pkg::ST_RESP:   state_in = lru_pkg::ST_IDLE;
         default:            state_in = lru_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         lru_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         lru_pkg::ST_CHECK:  cmd.check  = 1'b1;
         lru_pkg::ST_UNLINK: cmd.unlink = 1'b1;
         lru_pkg::ST_LINK_A: cmd.link_a = 1'b1;
         lru_pkg::ST_LINK_B: cmd.link_b = 1'b1;
         lru_pkg::ST_RESP:   rsp_valid  = 1'b1;
         default:            busy       = 1'b1;
      endcase
   end

endmodule
`default_nettype wire

### sv/lru_dpath.sv
// Link memories, membership bits and head/tail pointers of the LRU order list.
`default_nettype none
module lru_dpath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lru_pkg::req_type req_data,
   input  wire lru_pkg::cmd_type cmd,
   output lru_pkg::sts_type      sts,
   output lru_pkg::rsp_type      rsp_data
);

   localparam int IDX_W  = lru_pkg::IDX_W;
   localparam int LINK_W = lru_pkg::LINK_W;

   logic [LINK_W-1:0] next_mem [lru_pkg::ENTRIES];
   logic [LINK_W-1:0] prev_mem [lru_pkg::ENTRIES];

   lru_pkg::req_type     req_ff;
   logic                 err_ff;
   logic [lru_pkg::ENTRIES-1:0] in_list_ff, in_list_in;
   logic [LINK_W-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [LINK_W-1:0]    next_rd_ff, prev_rd_ff;

   logic                 next_we, prev_we;
   logic [IDX_W-1:0]     next_wa, prev_wa;
   logic [LINK_W-1:0]    next_wd, prev_wd;

   logic [IDX_W-1:0]     e_idx;
   logic [LINK_W-1:0]    e_link;
   logic                 in_range, present, bad_op;

   assign e_idx    = req_ff.entry_index;
   assign e_link   = LINK_W'(e_idx);
   assign in_range = e_link < lru_pkg::NONE_LINK;
   assign present  = in_list_ff[e_idx];
   assign bad_op   = (req_ff.operation != lru_pkg::OP_TOUCH) &&
                     (req_ff.operation != lru_pkg::OP_ADD) &&
                     (req_ff.operation != lru_pkg::OP_REMOVE);

   always_comb begin
      sts.is_add   = req_ff.operation == lru_pkg::OP_ADD;
      sts.is_touch = req_ff.operation == lru_pkg::OP_TOUCH;
      sts.at_head  = e_link == head_ff;
      sts.op_error = !in_range || bad_op ||
                     (sts.is_add && present) ||
                     (!sts.is_add && !present);
   end

   // link rewrites; one write per memory per cycle
   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      in_list_in = in_list_ff;
      next_we    = 1'b0;
      prev_we    = 1'b0;
      next_wa    = e_idx;
      prev_wa    = e_idx;
      next_wd    = lru_pkg::NONE_LINK;
      prev_wd    = lru_pkg::NONE_LINK;
      if (cmd.unlink) begin
         // prev_rd_ff / next_rd_ff hold the neighbors of the entry
         if (e_link == head_ff) begin
            head_in = next_rd_ff;
         end else if (prev_rd_ff < lru_pkg::NONE_LINK) begin
            next_we = 1'b1;
            next_wa = prev_rd_ff[IDX_W-1:0];
            next_wd = next_rd_ff;
         end
         if (e_link == tail_ff) begin
            tail_in = prev_rd_ff;
         end else if (next_rd_ff < lru_pkg::NONE_LINK) begin
            prev_we = 1'b1;
            prev_wa = next_rd_ff[IDX_W-1:0];
            prev_wd = prev_rd_ff;
         end
         if (req_ff.operation == lru_pkg::OP_REMOVE) in_list_in[e_idx] = 1'b0;
      end
      if (cmd.link_a) begin
         next_we = 1'b1;
         next_wd = head_ff;
         prev_we = 1'b1;
         prev_wd = lru_pkg::NONE_LINK;
      end
      if (cmd.link_b) begin
         if (head_ff >= lru_pkg::NONE_LINK) begin
            tail_in = e_link;
         end else begin
            prev_we = 1'b1;
            prev_wa = head_ff[IDX_W-1:0];
            prev_wd = e_link;
         end
         head_in            = e_link;
         in_list_in[e_idx]  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_list_ff <= '0;
         head_ff    <= lru_pkg::NONE_LINK;
         tail_ff    <= lru_pkg::NONE_LINK;
      end else begin
         in_list_ff <= in_list_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      if (cmd.check) err_ff <= sts.op_error;
   end

   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_wa] <= next_wd;
      if (cmd.check) next_rd_ff <= next_mem[e_idx];
   end

   always_ff @(posedge clock) begin
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      if (cmd.check) prev_rd_ff <= prev_mem[e_idx];
   end

   always_comb begin
      rsp_data.head_entry = head_ff;
      rsp_data.tail_entry = tail_ff;
      rsp_data.list_empty = head_ff >= lru_pkg::NONE_LINK;
      rsp_data.op_error   = err_ff;
   end

endmodule
`default_nettype wire

### sv/lru_order_list_unit.sv
// Top level of the LRU order list unit: controller, datapath and checks.
`default_nettype none
// True-LRU recency list over 64 entries held as a doubly linked list in two
// link memories (next and prev, one write port each). A transaction is taken
// when start is high and busy is low; its result appears on rsp_data for one
// cycle with rsp_valid high and must be taken then, the receiver cannot stall.
// Steps from accept: CHECK, RESP for a refused operation or a touch of the
// head; CHECK, UNLINK, RESP for remove; CHECK, LINK_A, LINK_B, RESP for add;
// CHECK, UNLINK, LINK_A, LINK_B, RESP for a touch of another entry. The lookup
// read of the links and the single write port of each link memory set these steps.
// Result: head, tail (least recently used), empty flag, error flag; on error
// the list is left unchanged. No clearing pass is needed after reset.
module lru_order_list_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire lru_pkg::req_type req_data,
   output logic                  rsp_valid,
   output lru_pkg::rsp_type      rsp_data
);

   lru_pkg::cmd_type cmd;
   lru_pkg::sts_type sts;

   lru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   lru_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted transaction");

   a_rsp_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result outside a transaction");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.list_empty ==
                     (rsp_data.tail_entry == lru_pkg::NONE_LINK)))
      else $error("empty flag disagrees with tail");
`endif

endmodule
`default_nettype wire
